[rtl/ubxp_pkg.sv]
// Shared types, constants and register codes for the frame parser.
`timescale 1ns / 1ps

package ubxp_pkg;

    // Frame buffer size that the echoed positions must fit in
    localparam int unsigned FRAME_BUFFER_BYTES = 2048;

    localparam int unsigned POS_W  = 11;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 11;

    // Header size: two sync bytes, class, id and two length bytes
    localparam logic [16:0] HEADER_BYTES = 17'd6;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET   = 8'hAC;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET  = 8'h62;
    localparam logic [POS_W-1:0]  LENGTH_LIMIT_RESET = 11'd1500;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_LIMIT = 2'd2;

    // Positions (counted from one) of the header bytes
    localparam logic [POS_W-1:0] CNT_FIRST_SYNC = 11'd1;
    localparam logic [POS_W-1:0] CNT_CLASS      = 11'd3;
    localparam logic [POS_W-1:0] CNT_IDENT      = 11'd4;
    localparam logic [POS_W-1:0] CNT_LEN_LOW    = 11'd5;
    localparam logic [POS_W-1:0] CNT_LEN_HIGH   = 11'd6;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } t_phase;

    // Parser state carried from one byte to the next
    typedef struct packed {
        t_phase              phase;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    expected_length;
        logic [BYTE_W-1:0]   sum_a;
        logic [BYTE_W-1:0]   sum_b;
        logic [BYTE_W-1:0]   held_class;
        logic [BYTE_W-1:0]   held_ident;
        logic [BYTE_W-1:0]   length_low;
    } t_state;

    // Configuration register set
    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [POS_W-1:0]  length_limit;
    } t_cfg;

    // One result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        logic [POS_W-1:0]  byte_position;
        logic              frame_done;
        logic [POS_W-1:0]  total_length;
        logic [BYTE_W-1:0] frame_class;
        logic [BYTE_W-1:0] frame_ident;
    } t_result;

endpackage

[rtl/ubxp_step.sv]
// Per-byte parser step: next state and result from current state and byte.
`timescale 1ns / 1ps

module ubxp_step (
    input  ubxp_pkg::t_state                  i_state,
    input  ubxp_pkg::t_cfg                    i_cfg,
    input  logic [ubxp_pkg::BYTE_W-1:0]       i_byte,
    output ubxp_pkg::t_state                  o_state,
    output ubxp_pkg::t_result                 o_result
);

    localparam logic [17:0] BUFFER_LIMIT = 18'(ubxp_pkg::FRAME_BUFFER_BYTES);

    logic [ubxp_pkg::POS_W-1:0]  cnt;
    logic [ubxp_pkg::POS_W-1:0]  check_a_cnt;
    logic [ubxp_pkg::BYTE_W-1:0] add_a;
    logic [ubxp_pkg::BYTE_W-1:0] add_b;
    logic [16:0]                 total;
    logic [17:0]                 total_plus2;
    logic                        length_ok;
    logic                        first_slot;
    logic                        at_check_a;
    logic                        check_b_ok;
    ubxp_pkg::t_phase            n_phase;

    // Counters and Fletcher running sums
    assign cnt         = i_state.position + 11'd1;
    assign check_a_cnt = i_state.expected_length + 11'd1;
    assign add_a       = i_state.sum_a + i_byte;
    assign add_b       = i_state.sum_b + add_a;
    assign first_slot  = (cnt == ubxp_pkg::CNT_FIRST_SYNC);
    assign at_check_a  = (cnt == check_a_cnt);
    assign check_b_ok  = (i_byte == i_state.sum_b);

    // Length check on the high length byte
    assign total       = {1'b0, i_byte, i_state.length_low} + ubxp_pkg::HEADER_BYTES;
    assign total_plus2 = {1'b0, total} + 18'd2;
    assign length_ok   = (total > ubxp_pkg::HEADER_BYTES)
                      && (total < {6'd0, i_cfg.length_limit})
                      && (total_plus2 <= BUFFER_LIMIT);

    // Next phase
    always_comb begin
        n_phase = i_state.phase;
        unique case (i_state.phase)
            ubxp_pkg::PH_HUNT: begin
                if (!first_slot && i_byte == i_cfg.sync_second) begin
                    n_phase = ubxp_pkg::PH_HEADER;
                end
            end
            ubxp_pkg::PH_HEADER: begin
                if (cnt == ubxp_pkg::CNT_LEN_HIGH) begin
                    n_phase = length_ok ? ubxp_pkg::PH_PAYLOAD : ubxp_pkg::PH_HUNT;
                end
            end
            ubxp_pkg::PH_PAYLOAD: begin
                if (cnt == i_state.expected_length) begin
                    n_phase = ubxp_pkg::PH_CHECK;
                end
            end
            ubxp_pkg::PH_CHECK: begin
                if (!at_check_a || i_byte != i_state.sum_a) begin
                    n_phase = ubxp_pkg::PH_HUNT;
                end
            end
            default: n_phase = ubxp_pkg::PH_HUNT;
        endcase
    end

    // Datapath state and result
    always_comb begin
        o_state       = i_state;
        o_state.phase = n_phase;
        o_state.position = cnt;

        o_result               = '0;
        o_result.echo_byte     = i_byte;
        o_result.byte_position = i_state.position;

        unique case (i_state.phase)
            ubxp_pkg::PH_HUNT: begin
                if (first_slot) begin
                    if (i_byte != i_cfg.sync_first) begin
                        o_state.position = '0;
                    end
                end else if (i_byte == i_cfg.sync_second) begin
                    o_state.sum_a = '0;
                    o_state.sum_b = '0;
                end else begin
                    o_state.position = '0;
                end
            end
            ubxp_pkg::PH_HEADER: begin
                o_state.sum_a = add_a;
                o_state.sum_b = add_b;
                priority if (cnt == ubxp_pkg::CNT_CLASS) begin
                    o_state.held_class = i_byte;
                end else if (cnt == ubxp_pkg::CNT_IDENT) begin
                    o_state.held_ident = i_byte;
                end else if (cnt == ubxp_pkg::CNT_LEN_LOW) begin
                    o_state.length_low = i_byte;
                end else if (cnt == ubxp_pkg::CNT_LEN_HIGH) begin
                    if (length_ok) begin
                        o_state.expected_length = total[ubxp_pkg::POS_W-1:0];
                    end else begin
                        o_state.position = '0;
                    end
                end
            end
            ubxp_pkg::PH_PAYLOAD: begin
                o_state.sum_a = add_a;
                o_state.sum_b = add_b;
            end
            ubxp_pkg::PH_CHECK: begin
                if (at_check_a) begin
                    if (i_byte != i_state.sum_a) begin
                        o_state.position = '0;
                    end
                end else begin
                    o_state.position = '0;
                    if (check_b_ok) begin
                        o_result.frame_done   = 1'b1;
                        o_result.total_length = i_state.expected_length;
                        o_result.frame_class  = i_state.held_class;
                        o_result.frame_ident  = i_state.held_ident;
                    end
                end
            end
            default: o_state.position = '0;
        endcase
    end

endmodule

[rtl/ubx_frame_parser_unit.sv]
// Top level of the binary navigation frame parser.
`timescale 1ns / 1ps

// Frame parser: takes one received byte per transaction, echoes it with its
// frame buffer position and flags the byte that ends a frame whose Fletcher-8
// check passed, reporting total length, class and id. The state update is a
// single pass through the step logic between the state registers and the
// result register, so a new byte is accepted every cycle as long as the
// result register is empty or being drained in the same cycle (i_ready low
// stalls input through o_ready). The result of each byte is registered.
// Configuration writes are always accepted and should only be made while
// the parser is idle.
module ubx_frame_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ubxp_pkg::BYTE_W-1:0]         i_rx_byte,
    // result output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ubxp_pkg::BYTE_W-1:0]         o_echo_byte,
    output logic [ubxp_pkg::POS_W-1:0]          o_byte_position,
    output logic                                o_frame_done,
    output logic [ubxp_pkg::POS_W-1:0]          o_total_length,
    output logic [ubxp_pkg::BYTE_W-1:0]         o_frame_class,
    output logic [ubxp_pkg::BYTE_W-1:0]         o_frame_ident,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ubxp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [ubxp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    ubxp_pkg::t_cfg    r_cfg;
    ubxp_pkg::t_state  r_state;
    ubxp_pkg::t_state  n_state;
    ubxp_pkg::t_result r_result;
    ubxp_pkg::t_result n_result;
    logic              r_out_valid;
    logic              in_take;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign in_take     = i_valid && o_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first   <= ubxp_pkg::SYNC_FIRST_RESET;
            r_cfg.sync_second  <= ubxp_pkg::SYNC_SECOND_RESET;
            r_cfg.length_limit <= ubxp_pkg::LENGTH_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ubxp_pkg::REG_SYNC_FIRST:   r_cfg.sync_first   <= i_cfg_data[7:0];
                ubxp_pkg::REG_SYNC_SECOND:  r_cfg.sync_second  <= i_cfg_data[7:0];
                ubxp_pkg::REG_LENGTH_LIMIT: r_cfg.length_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Step logic
    ubxp_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_byte   (i_rx_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Parser state, updated on each accepted byte; all zero is hunting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_echo_byte     = r_result.echo_byte;
    assign o_byte_position = r_result.byte_position;
    assign o_frame_done    = r_result.frame_done;
    assign o_total_length  = r_result.total_length;
    assign o_frame_class   = r_result.frame_class;
    assign o_frame_ident   = r_result.frame_ident;

endmodule

[rtl/ubxp_checker.sv]
// Port-level assertions for the frame parser, bound to the top level.
`timescale 1ns / 1ps

module ubxp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [ubxp_pkg::BYTE_W-1:0]   o_echo_byte,
    input logic [ubxp_pkg::POS_W-1:0]    o_byte_position,
    input logic                          o_frame_done,
    input logic [ubxp_pkg::POS_W-1:0]    o_total_length,
    input logic [ubxp_pkg::BYTE_W-1:0]   o_frame_class,
    input logic [ubxp_pkg::BYTE_W-1:0]   o_frame_ident
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_echo_byte)
            && $stable(o_byte_position) && $stable(o_frame_done)))
        else $error("result changed while stalled");

    // The completing byte is the second check byte, one past the frame length
    a_done_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> (o_byte_position == o_total_length + 11'd1))
        else $error("frame done at wrong position");

    // A completed frame has at least one payload byte and fits the limit range
    a_done_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> (o_total_length >= 11'd7 && o_total_length != 11'd2047))
        else $error("frame done with impossible length");

    // Frame info fields stay zero on ordinary bytes
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_done) |->
            (o_total_length == '0 && o_frame_class == '0 && o_frame_ident == '0))
        else $error("frame info set without frame done");

endmodule

bind ubx_frame_parser_unit ubxp_checker u_ubxp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_echo_byte     (o_echo_byte),
    .o_byte_position (o_byte_position),
    .o_frame_done    (o_frame_done),
    .o_total_length  (o_total_length),
    .o_frame_class   (o_frame_class),
    .o_frame_ident   (o_frame_ident)
);

[tb/ubx_frame_checker.sv]
// Scoreboard for the frame parser: predicts each result transaction and compares it.
`timescale 1ns / 1ps

module ubx_frame_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // byte channel
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [ubxp_pkg::BYTE_W-1:0]        i_rx_byte,
    // result channel
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [ubxp_pkg::BYTE_W-1:0]        i_echo_byte,
    input  logic [ubxp_pkg::POS_W-1:0]         i_byte_position,
    input  logic                               i_frame_done,
    input  logic [ubxp_pkg::POS_W-1:0]         i_total_length,
    input  logic [ubxp_pkg::BYTE_W-1:0]        i_frame_class,
    input  logic [ubxp_pkg::BYTE_W-1:0]        i_frame_ident,
    // register write channel
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [ubxp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ubxp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // totals for the top
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_frames
);

    // two check bytes follow the payload
    localparam int unsigned CHECK_BYTES = 2;

    // register copies
    logic [ubxp_pkg::BYTE_W-1:0] sync1_cfg;
    logic [ubxp_pkg::BYTE_W-1:0] sync2_cfg;
    logic [ubxp_pkg::POS_W-1:0]  limit_cfg;

    // parser state as predicted
    ubxp_pkg::t_phase            parse_ph;
    logic [ubxp_pkg::POS_W-1:0]  slot;
    logic [ubxp_pkg::POS_W-1:0]  frame_len;
    logic [ubxp_pkg::BYTE_W-1:0] fl_a;
    logic [ubxp_pkg::BYTE_W-1:0] fl_b;
    logic [ubxp_pkg::BYTE_W-1:0] cls_seen;
    logic [ubxp_pkg::BYTE_W-1:0] id_seen;
    logic [ubxp_pkg::BYTE_W-1:0] len_lo;

    // results predicted but not yet seen on the output
    ubxp_pkg::t_result pending_results[$];

    // Count and report one failure
    task automatic note_failure(input string msg);
        $error("%s", msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            note_failure($sformatf("%s mismatch: expected 0x%0h, actual 0x%0h",
                                   name, want, got));
    endtask

    // Advance the predicted parser by one byte and return the result it gives
    function automatic ubxp_pkg::t_result advance_parser(
        input logic [ubxp_pkg::BYTE_W-1:0] rx);
        ubxp_pkg::t_result          res;
        logic [ubxp_pkg::POS_W-1:0] nxt;
        int unsigned                total;
        res = '0;
        res.echo_byte = rx;
        res.byte_position = slot;
        nxt = slot + 1'b1;
        slot = nxt;

        // Fletcher sums run over class through the last payload byte
        if (parse_ph == ubxp_pkg::PH_HEADER || parse_ph == ubxp_pkg::PH_PAYLOAD) begin
            fl_a = fl_a + rx;
            fl_b = fl_b + fl_a;
        end

        case (parse_ph)
            ubxp_pkg::PH_HUNT: begin
                if (nxt == ubxp_pkg::CNT_FIRST_SYNC) begin
                    if (rx != sync1_cfg)
                        slot = '0;
                end else if (rx == sync2_cfg) begin
                    parse_ph = ubxp_pkg::PH_HEADER;
                    fl_a = '0;
                    fl_b = '0;
                end else begin
                    // failed second sync is not retried as a first sync
                    slot = '0;
                end
            end
            ubxp_pkg::PH_HEADER: begin
                if (nxt == ubxp_pkg::CNT_CLASS) begin
                    cls_seen = rx;
                end else if (nxt == ubxp_pkg::CNT_IDENT) begin
                    id_seen = rx;
                end else if (nxt == ubxp_pkg::CNT_LEN_LOW) begin
                    len_lo = rx;
                end else if (nxt == ubxp_pkg::CNT_LEN_HIGH) begin
                    total = {rx, len_lo} + ubxp_pkg::HEADER_BYTES;
                    if (total > ubxp_pkg::HEADER_BYTES && total < limit_cfg &&
                        total + CHECK_BYTES <= ubxp_pkg::FRAME_BUFFER_BYTES) begin
                        frame_len = total[ubxp_pkg::POS_W-1:0];
                        parse_ph = ubxp_pkg::PH_PAYLOAD;
                    end else begin
                        parse_ph = ubxp_pkg::PH_HUNT;
                        slot = '0;
                    end
                end
            end
            ubxp_pkg::PH_PAYLOAD: begin
                if (nxt == frame_len)
                    parse_ph = ubxp_pkg::PH_CHECK;
            end
            default: begin
                if (nxt == frame_len + 1'b1) begin
                    // check A: a wrong byte drops the frame
                    if (rx != fl_a) begin
                        parse_ph = ubxp_pkg::PH_HUNT;
                        slot = '0;
                    end
                end else begin
                    // check B ends the frame either way
                    parse_ph = ubxp_pkg::PH_HUNT;
                    slot = '0;
                    if (rx == fl_b) begin
                        res.frame_done = 1'b1;
                        res.total_length = frame_len;
                        res.frame_class = cls_seen;
                        res.frame_ident = id_seen;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Watch the three channels
    always @(posedge i_clk) begin : watch
        ubxp_pkg::t_result got;
        ubxp_pkg::t_result want;
        if (!i_rst_n) begin
            sync1_cfg = ubxp_pkg::SYNC_FIRST_RESET;
            sync2_cfg = ubxp_pkg::SYNC_SECOND_RESET;
            limit_cfg = ubxp_pkg::LENGTH_LIMIT_RESET;
            parse_ph = ubxp_pkg::PH_HUNT;
            slot = '0;
            frame_len = '0;
            fl_a = '0;
            fl_b = '0;
            cls_seen = '0;
            id_seen = '0;
            len_lo = '0;
            pending_results.delete();
        end else begin
            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ubxp_pkg::REG_SYNC_FIRST:
                        sync1_cfg = i_cfg_data[ubxp_pkg::BYTE_W-1:0];
                    ubxp_pkg::REG_SYNC_SECOND:
                        sync2_cfg = i_cfg_data[ubxp_pkg::BYTE_W-1:0];
                    ubxp_pkg::REG_LENGTH_LIMIT:
                        limit_cfg = i_cfg_data[ubxp_pkg::POS_W-1:0];
                    default: ;
                endcase
            end

            // result transaction: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got = {i_echo_byte, i_byte_position, i_frame_done,
                       i_total_length, i_frame_class, i_frame_ident};
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: echo_byte 0x%0h position %0d",
                                           got.echo_byte, got.byte_position));
                end else begin
                    want = pending_results.pop_front();
                    check_field("echo_byte", want.echo_byte, got.echo_byte);
                    check_field("byte_position", want.byte_position, got.byte_position);
                    check_field("frame_done", want.frame_done, got.frame_done);
                    check_field("total_length", want.total_length, got.total_length);
                    check_field("frame_class", want.frame_class, got.frame_class);
                    check_field("frame_ident", want.frame_ident, got.frame_ident);
                    o_checked++;
                    if (want.frame_done)
                        o_frames++;
                end
            end

            // byte transaction: predict its result
            if (i_in_valid && i_in_ready)
                pending_results.push_back(advance_parser(i_rx_byte));
        end
        o_pending = pending_results.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the frame parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    // generous bound on the whole run
    localparam int CYCLE_LIMIT = 400000;
    // index with no register behind it
    localparam logic [ubxp_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    // cycles to let pass once nothing is expected any more
    localparam int SETTLE_CYCLES = 8;

    typedef enum {FR_GOOD, FR_BAD_SYNC, FR_BAD_LEN, FR_BAD_CK_A, FR_BAD_CK_B} t_frame_kind;

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic [ubxp_pkg::BYTE_W-1:0]      i_rx_byte = '0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic [ubxp_pkg::BYTE_W-1:0]      o_echo_byte;
    logic [ubxp_pkg::POS_W-1:0]       o_byte_position;
    logic                             o_frame_done;
    logic [ubxp_pkg::POS_W-1:0]       o_total_length;
    logic [ubxp_pkg::BYTE_W-1:0]      o_frame_class;
    logic [ubxp_pkg::BYTE_W-1:0]      o_frame_ident;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [ubxp_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [ubxp_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    int fail_count;
    int pending_count;
    int checked_count;
    int frame_count;

    int cycle_count = 0;
    int bytes_sent = 0;
    int settings_run = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // register values the stimulus builds frames for
    logic [ubxp_pkg::BYTE_W-1:0] cur_sync1 = ubxp_pkg::SYNC_FIRST_RESET;
    logic [ubxp_pkg::BYTE_W-1:0] cur_sync2 = ubxp_pkg::SYNC_SECOND_RESET;
    int                          cur_limit = ubxp_pkg::LENGTH_LIMIT_RESET;

    // running Fletcher sums of the frame being sent
    logic [ubxp_pkg::BYTE_W-1:0] run_a;
    logic [ubxp_pkg::BYTE_W-1:0] run_b;

    ubx_frame_parser_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_echo_byte     (o_echo_byte),
        .o_byte_position (o_byte_position),
        .o_frame_done    (o_frame_done),
        .o_total_length  (o_total_length),
        .o_frame_class   (o_frame_class),
        .o_frame_ident   (o_frame_ident),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    ubx_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_echo_byte     (o_echo_byte),
        .i_byte_position (o_byte_position),
        .i_frame_done    (o_frame_done),
        .i_total_length  (o_total_length),
        .i_frame_class   (o_frame_class),
        .i_frame_ident   (o_frame_ident),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_checked       (checked_count),
        .o_frames        (frame_count)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure at the current stall rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL ubx_frame_parser_unit");
            $finish;
        end
    end

    // One byte transaction, with a random gap in front at the current idle rate
    task automatic send_byte(input logic [ubxp_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    // Send a byte that the frame check covers
    task automatic send_summed(input logic [ubxp_pkg::BYTE_W-1:0] b);
        run_a = run_a + b;
        run_b = run_b + run_a;
        send_byte(b);
    endtask

    // One register write transaction; valid is lowered by the caller
    task automatic write_reg(input logic [ubxp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ubxp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write every register; spare upper data bits on the sync registers are random
    task automatic apply_settings(input logic [ubxp_pkg::BYTE_W-1:0] s1,
                                  input logic [ubxp_pkg::BYTE_W-1:0] s2,
                                  input logic [ubxp_pkg::POS_W-1:0] lim);
        write_reg(REG_UNUSED, ubxp_pkg::CFG_DATA_W'($urandom));
        write_reg(ubxp_pkg::REG_SYNC_FIRST, {3'($urandom), s1});
        write_reg(ubxp_pkg::REG_SYNC_SECOND, {3'($urandom), s2});
        write_reg(ubxp_pkg::REG_LENGTH_LIMIT, lim);
        i_cfg_valid <= 1'b0;
        cur_sync1 = s1;
        cur_sync2 = s2;
        cur_limit = lim;
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        @(posedge i_clk);
    endtask

    // Send a frame, or a broken one; fill < 0 means random payload
    task automatic send_frame(input t_frame_kind kind, input logic [ubxp_pkg::BYTE_W-1:0] cls,
                              input logic [ubxp_pkg::BYTE_W-1:0] ident, input int plen,
                              input int fill);
        logic [15:0]                 len16;
        logic [ubxp_pkg::BYTE_W-1:0] bad;
        len16 = plen[15:0];
        send_byte(cur_sync1);
        if (kind == FR_BAD_SYNC) begin
            bad = (cur_sync1 != cur_sync2) ? cur_sync1
                                           : cur_sync2 ^ 8'($urandom_range(255, 1));
            send_byte(bad);
            return;
        end
        send_byte(cur_sync2);
        run_a = '0;
        run_b = '0;
        send_summed(cls);
        send_summed(ident);
        send_summed(len16[7:0]);
        send_summed(len16[15:8]);
        if (kind == FR_BAD_LEN)
            return;
        for (int k = 0; k < plen; k++)
            send_summed((fill < 0) ? 8'($urandom) : 8'(fill));
        send_byte((kind == FR_BAD_CK_A) ? run_a ^ 8'($urandom_range(255, 1)) : run_a);
        send_byte((kind == FR_BAD_CK_B) ? run_b ^ 8'($urandom_range(255, 1)) : run_b);
    endtask

    // One random piece of traffic: mostly frames, some broken, some noise
    task automatic random_frame();
        int pick;
        int maxp;
        int plen;
        int lenpick;
        maxp = (cur_limit > 7) ? cur_limit - 7 : 8;
        if ($urandom_range(29) == 0)
            plen = $urandom_range((maxp < 300) ? maxp : 300, 1);
        else
            plen = $urandom_range((maxp < 24) ? maxp : 24, 1);
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
        end else if (pick < 68) begin
            send_frame(FR_GOOD, 8'($urandom), 8'($urandom), plen, -1);
        end else if (pick < 76) begin
            send_frame(FR_BAD_CK_A, 8'($urandom), 8'($urandom), plen, -1);
        end else if (pick < 84) begin
            send_frame(FR_BAD_CK_B, 8'($urandom), 8'($urandom), plen, -1);
        end else if (pick < 92) begin
            // empty payload, total right at the limit, or far too long
            lenpick = $urandom_range(2);
            if (lenpick == 0)
                plen = 0;
            else if (lenpick == 1)
                plen = (cur_limit >= 6) ? cur_limit - 6 : 0;
            else
                plen = $urandom_range(65535, 2048);
            send_frame(FR_BAD_LEN, 8'($urandom), 8'($urandom), plen, -1);
        end else begin
            send_frame(FR_BAD_SYNC, 8'($urandom), 8'($urandom), plen, -1);
            send_frame(FR_GOOD, 8'($urandom), 8'($urandom), plen, -1);
        end
    endtask

    // One register setting with its own idle pattern, ending idle
    task automatic run_phase(input bit write_cfg, input logic [ubxp_pkg::BYTE_W-1:0] s1,
                             input logic [ubxp_pkg::BYTE_W-1:0] s2,
                             input logic [ubxp_pkg::POS_W-1:0] lim,
                             input int send_pct, input int stall_v, input int budget);
        int target;
        if (write_cfg)
            apply_settings(s1, s2, lim);
        send_idle_pct = send_pct;
        stall_pct = stall_v;
        target = bytes_sent + budget;
        while (bytes_sent < target)
            random_frame();
        wait_idle();
        settings_run++;
    endtask

    // Stimulus and verdict
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: shortest good frame with extreme bytes
        send_frame(FR_GOOD, 8'h00, 8'hFF, 1, 8'hFF);
        // second sync wrong, and that byte is a first sync
        send_byte(ubxp_pkg::SYNC_FIRST_RESET);
        send_byte(ubxp_pkg::SYNC_FIRST_RESET);
        // empty payload gives a total of six
        send_frame(FR_BAD_LEN, 8'hFF, 8'h00, 0, -1);
        // wrong check A
        send_frame(FR_BAD_CK_A, 8'h01, 8'h02, 1, 8'h00);

        // reset settings, then extremes and random settings under each idle pattern
        run_phase(1'b0, ubxp_pkg::SYNC_FIRST_RESET, ubxp_pkg::SYNC_SECOND_RESET,
                  ubxp_pkg::LENGTH_LIMIT_RESET, 0, 0, 230);
        run_phase(1'b1, 8'hFF, 8'h00, 11'd2046, 81, 0, 230);
        run_phase(1'b1, 8'h00, 8'hFF, 11'd7, 0, 81, 230);
        run_phase(1'b1, 8'hB5, 8'h62, 11'd0, 32, 32, 140);
        run_phase(1'b1, 8'h5A, 8'h5A, 11'd2047, 32, 32, 230);
        run_phase(1'b1, 8'($urandom), 8'($urandom), 11'($urandom_range(600, 40)),
                  0, 0, 230);
        run_phase(1'b1, 8'($urandom), 8'($urandom), ubxp_pkg::LENGTH_LIMIT_RESET,
                  81, 0, 190);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        $display("Sent %0d bytes under %0d register settings and four idle patterns",
                 bytes_sent, settings_run);
        $display("%0d results compared, %0d of them completed frames",
                 checked_count, frame_count);
        if (fail_count == 0) begin
            $display("PASS ubx_frame_parser_unit");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAIL ubx_frame_parser_unit");
        end
        $finish;
    end

endmodule
